// ===== src/sil_pkg.sv =====
`default_nettype none
package sil_pkg;

  // Signed data word held in each cell.
  typedef logic signed [31:0] value_t;

  // Input operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ENTRY    = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;  // insert the new value this cycle
    logic   rot;  // rotate the occupied cells by one place toward the head
    value_t x;    // value being inserted
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/sil_cell.sv =====
`default_nettype none
module sil_cell (
  input  wire               clk,
  input  wire               rst_n,
  input  sil_pkg::cell_ctrl_t ctrl,
  input  sil_pkg::value_t   left_val,
  input  wire               left_vld,
  input  wire               left_keep,
  input  sil_pkg::value_t   right_val,
  input  wire               right_vld,
  input  sil_pkg::value_t   head_val,
  output sil_pkg::value_t   val,
  output logic              vld,
  output logic              keep
);
  import sil_pkg::*;

  value_t val_r, val_nxt;
  logic   vld_r, vld_nxt;

  // The cell keeps its entry when that entry is smaller than the new value.
  assign keep = vld_r && (val_r < ctrl.x);

  // Next contents: shift up on insert, move toward the head on rotate.
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctrl.ins) begin
      vld_nxt = vld_r | left_vld;
      if (!keep) begin
        val_nxt = left_keep ? ctrl.x : left_val;
      end
    end else if (ctrl.rot && vld_r) begin
      // The last occupied cell receives the entry leaving the head.
      val_nxt = right_vld ? right_val : head_val;
    end
  end

  // Occupancy flag is control state; the stored word needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule
`default_nettype wire

// ===== src/sorted_insertion_list_unit.sv =====
`default_nettype none
// Sorted list of up to CAPACITY signed 32-bit values, held in a chain of
// compare-and-shift cells. An insert gives one result (inserted, or full
// and dropped). A dump of n stored entries streams them in ascending order,
// one per cycle while out_ready holds, by rotating the occupied cells past
// the head; a dump of an empty list gives a single empty result. The
// accepting cycle of a dump loads no result. The next item is accepted
// once the dump's last result is loaded into the output register and that
// register is free to take a new result. The list is left unchanged by a dump.
module sorted_insertion_list_unit #(
  parameter int CAPACITY = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                in_opcode,
  input  sil_pkg::value_t    in_value,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [1:0]         out_status,
  output sil_pkg::value_t    out_entry,
  output logic               out_last
);
  import sil_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Chain signals.
  value_t     cell_val  [CAPACITY];
  logic       cell_vld  [CAPACITY];
  logic       cell_keep [CAPACITY];
  cell_ctrl_t ctrl;

  // Control registers.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  value_t           entry_r, entry_nxt;
  logic             last_r, last_nxt;

  logic slot_free, in_xfer, full;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !busy_r && slot_free;
  assign in_xfer   = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(CAPACITY));

  // Command decode and result generation.
  always_comb begin
    count_nxt     = count_r;
    left_nxt      = left_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    entry_nxt     = entry_r;
    last_nxt      = last_r;
    ctrl.ins      = 1'b0;
    ctrl.rot      = 1'b0;
    ctrl.x        = in_value;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      entry_nxt     = '0;
      last_nxt      = 1'b1;
      if (in_opcode == OP_INSERT) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          ctrl.ins   = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
        end
      end else if (count_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        // Dump start: results are produced from the next cycle on.
        out_valid_nxt = 1'b0;
        busy_nxt      = 1'b1;
        left_nxt      = count_r;
      end
    end else if (busy_r && slot_free) begin
      // Stream the head entry and rotate the chain by one place.
      out_valid_nxt = 1'b1;
      status_nxt    = ST_ENTRY;
      entry_nxt     = cell_val[0];
      last_nxt      = (left_r == CNT_W'(1));
      ctrl.rot      = 1'b1;
      left_nxt      = left_r - CNT_W'(1);
      if (left_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      left_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    entry_r  <= entry_nxt;
    last_r   <= last_nxt;
  end

  // Cell chain; cell zero holds the smallest entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t lval, rval;
    logic   lvld, lkeep, rvld;
    if (i == 0) begin : g_head
      assign lval  = in_value;
      assign lvld  = 1'b1;
      assign lkeep = 1'b1;
    end else begin : g_body
      assign lval  = cell_val[i-1];
      assign lvld  = cell_vld[i-1];
      assign lkeep = cell_keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rval = cell_val[0];
      assign rvld = 1'b0;
    end else begin : g_mid
      assign rval = cell_val[i+1];
      assign rvld = cell_vld[i+1];
    end
    sil_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_val  (lval),
      .left_vld  (lvld),
      .left_keep (lkeep),
      .right_val (rval),
      .right_vld (rvld),
      .head_val  (cell_val[0]),
      .val       (cell_val[i]),
      .vld       (cell_vld[i]),
      .keep      (cell_keep[i])
    );
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_entry  = entry_r;
  assign out_last   = last_r;

endmodule
`default_nettype wire
